@@ rtl/csem_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the counting semaphore table.
// No dependencies; imported by the core and by the slot map.
package csem_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_OPEN  = 2'd0,
      REQ_CLOSE = 2'd1,
      REQ_WAIT  = 2'd2,
      REQ_POST  = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOT_OPEN = 3'd1,
      ST_NO_SLOT  = 3'd2,
      ST_QFULL    = 3'd3,
      ST_SAT      = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_WAKE = 2'd2
   } seq_state_type;

   // Update to the slot occupancy map
   typedef struct packed {
      logic set;
      logic clr;
   } map_op_type;

   localparam int SEM_ID_W   = 4;
   localparam int INIT_W     = 16;
   localparam int PID_PORT_W = 8;

endpackage

@@ rtl/counting_semaphore_table_core.sv @@
`timescale 1ns / 1ps
// Counting semaphore table: top level with request sequencer and result register.
// Depends on csem_pkg, csem_ram and csem_slot_map.
//
// Usage
//   Requests arrive on the req_ stream: req_tuser carries the request kind
//   (open, close, wait, post), req_tdata the slot, initial count and caller pid.
//   Each request gives exactly one result transaction on the rsp_ stream.
//   One request is in flight at a time. Accept happens in the idle state and
//   issues the read of the slot record; the next cycle checks and updates it.
//   Open, close, wait and a post with no waiter finish in the check state. A post that
//   wakes a waiter goes on to a wake state, since the waiter memory is addressed by the
//   queue head read from the slot memory. So the request rate is set by the
//   read-modify-write of the slot memory and the dependent waiter read.
//   The result is held in an output register; the next request is accepted
//   while a finished result still waits. If rsp_tready stays low the sequencer
//   holds its finished request until the register frees; its memory updates wait
//   with it, except a hand-over, which pops the queue head first and holds the pid.
//   Reset (synchronous, active high) clears the occupancy flags, the sequencer
//   and the result valid. Memories need no clearing: a slot record is loaded
//   by open before it is used, and waiter entries are read only once queued.
module counting_semaphore_table_core #(
   parameter int NUM_SEMS    = 16,
   parameter int QUEUE_DEPTH = 8,
   parameter int PID_BITS    = 8,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [31:0] req_tdata,   // [3:0] sem_id, [19:4] init_value, [27:20] pid, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [2:0] status, [6:3] slot_out, [7] granted,
                                    // [8] woke, [16:9] woke_pid, zero pad
);
   import csem_pkg::*;

   localparam int SLOT_W     = $clog2(NUM_SEMS);
   localparam int QW         = $clog2(QUEUE_DEPTH);
   localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REC_W      = COUNT_BITS + QW + LEN_W;
   localparam int WAIT_DEPTH = NUM_SEMS * QUEUE_DEPTH;
   localparam int WAIT_AW    = $clog2(WAIT_DEPTH);
   localparam int CMP_W      = (COUNT_BITS > INIT_W) ? COUNT_BITS : INIT_W;

   // Unpack request
   logic [SEM_ID_W-1:0]   in_sem_id;
   logic [INIT_W-1:0]     in_init;
   logic [PID_PORT_W-1:0] in_pid;
   logic                  req_take;

   assign in_sem_id = req_tdata[3:0];
   assign in_init   = req_tdata[19:4];
   assign in_pid    = req_tdata[27:20];

   // Sequencer and request registers
   seq_state_type         state_ff, state_in;
   req_kind_type          kind_ff;
   logic [SEM_ID_W-1:0]   id_ff;
   logic [INIT_W-1:0]     init_ff;
   logic [PID_BITS-1:0]   pid_ff;

   // Result register
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [SEM_ID_W-1:0]   slot_ff;
   logic                  granted_ff;
   logic                  woke_ff;
   logic [PID_PORT_W-1:0] woke_pid_ff;

   // Result staged by the sequencer
   logic                  commit;
   status_type            res_status;
   logic [SEM_ID_W-1:0]   res_slot;
   logic                  res_granted;
   logic                  res_woke;
   logic [PID_PORT_W-1:0] res_woke_pid;

   // Memory ports
   logic                  slot_we;
   logic [SLOT_W-1:0]     slot_waddr;
   logic [REC_W-1:0]      slot_wdata;
   logic [REC_W-1:0]      slot_rdata;
   logic                  wait_we;
   logic [WAIT_AW-1:0]    wait_waddr;
   logic                  wait_re;
   logic [WAIT_AW-1:0]    wait_raddr;
   logic [PID_BITS-1:0]   wait_rdata;

   // Occupancy map
   map_op_type            map_op;
   logic [SLOT_W-1:0]     map_op_idx;
   logic                  look_open;
   logic                  any_free;
   logic [SLOT_W-1:0]     free_idx;

   logic                  out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   csem_ram #(
      .DEPTH (NUM_SEMS),
      .WIDTH (REC_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (req_take),
      .rd_addr (SLOT_W'(in_sem_id)),
      .rd_data (slot_rdata)
   );

   csem_ram #(
      .DEPTH (WAIT_DEPTH),
      .WIDTH (PID_BITS)
   ) u_wait_ram (
      .clock   (clock),
      .wr_en   (wait_we),
      .wr_addr (wait_waddr),
      .wr_data (pid_ff),
      .rd_en   (wait_re),
      .rd_addr (wait_raddr),
      .rd_data (wait_rdata)
   );

   csem_slot_map #(
      .NUM_SEMS (NUM_SEMS)
   ) u_slot_map (
      .clock     (clock),
      .reset     (reset),
      .op        (map_op),
      .op_idx    (map_op_idx),
      .look_idx  (SLOT_W'(id_ff)),
      .look_open (look_open),
      .any_free  (any_free),
      .free_idx  (free_idx)
   );

   // Decode the slot record and work out the request
   logic [COUNT_BITS-1:0] rec_count;
   logic [QW-1:0]         rec_head;
   logic [LEN_W-1:0]      rec_len;
   logic [SLOT_W-1:0]     id_idx;
   logic                  slot_valid;
   logic [CMP_W-1:0]      init_ext;
   logic [CMP_W-1:0]      max_ext;
   logic [COUNT_BITS-1:0] init_clamped;
   logic [QW:0]           tail_sum;
   logic [QW-1:0]         tail_pos;
   logic [QW-1:0]         head_next;
   logic [WAIT_AW-1:0]    wait_base;
   logic                  has_waiter;
   logic                  queue_full;
   logic                  count_max;

   always_comb begin
      {rec_count, rec_head, rec_len} = slot_rdata;
      id_idx       = SLOT_W'(id_ff);
      slot_valid   = (int'(id_ff) < NUM_SEMS) && look_open;
      init_ext     = CMP_W'(init_ff);
      max_ext      = CMP_W'({COUNT_BITS{1'b1}});
      init_clamped = COUNT_BITS'((init_ext > max_ext) ? max_ext : init_ext);
      // wrap the tail position: head + len stays below twice the depth
      tail_sum     = (QW + 1)'(rec_head) + (QW + 1)'(rec_len);
      tail_pos     = (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                     QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);
      head_next    = (rec_head == QW'(QUEUE_DEPTH - 1)) ? '0 : rec_head + QW'(1);
      wait_base    = WAIT_AW'(id_idx) * WAIT_AW'(QUEUE_DEPTH);
      has_waiter   = (rec_len != '0);
      queue_full   = (rec_len == LEN_W'(QUEUE_DEPTH));
      count_max    = (rec_count == {COUNT_BITS{1'b1}});
   end

   // Next state, memory updates and result
   always_comb begin
      state_in     = state_ff;
      commit       = 1'b0;
      res_status   = ST_OK;
      res_slot     = id_ff;
      res_granted  = 1'b0;
      res_woke     = 1'b0;
      res_woke_pid = '0;
      slot_we      = 1'b0;
      slot_waddr   = id_idx;
      slot_wdata   = slot_rdata;
      wait_we      = 1'b0;
      wait_waddr   = wait_base + WAIT_AW'(tail_pos);
      wait_re      = 1'b0;
      wait_raddr   = wait_base + WAIT_AW'(rec_head);
      map_op       = '0;
      map_op_idx   = id_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (kind_ff == REQ_POST && slot_valid && has_waiter) begin
               // hand over: pop the head now, deliver the pid once it is read
               slot_we    = 1'b1;
               slot_wdata = {rec_count, head_next, rec_len - LEN_W'(1)};
               wait_re    = 1'b1;
               state_in   = S_WAKE;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
               case (kind_ff)
                  REQ_OPEN: begin
                     if (!any_free) begin
                        res_status = ST_NO_SLOT;
                     end else begin
                        res_slot   = SEM_ID_W'(free_idx);
                        map_op.set = 1'b1;
                        map_op_idx = free_idx;
                        slot_we    = 1'b1;
                        slot_waddr = free_idx;
                        slot_wdata = {init_clamped, QW'(0), LEN_W'(0)};
                     end
                  end
                  REQ_CLOSE: begin
                     if (!slot_valid) begin
                        res_status = ST_NOT_OPEN;
                     end else begin
                        map_op.clr = 1'b1;
                     end
                  end
                  REQ_WAIT: begin
                     if (!slot_valid) begin
                        res_status = ST_NOT_OPEN;
                     end else if (rec_count != '0) begin
                        res_granted = 1'b1;
                        slot_we     = 1'b1;
                        slot_wdata  = {rec_count - COUNT_BITS'(1), rec_head, rec_len};
                     end else if (queue_full) begin
                        res_status = ST_QFULL;
                     end else begin
                        wait_we    = 1'b1;
                        slot_we    = 1'b1;
                        slot_wdata = {rec_count, rec_head, rec_len + LEN_W'(1)};
                     end
                  end
                  REQ_POST: begin
                     if (!slot_valid) begin
                        res_status = ST_NOT_OPEN;
                     end else if (count_max) begin
                        res_status = ST_SAT;
                     end else begin
                        slot_we    = 1'b1;
                        slot_wdata = {rec_count + COUNT_BITS'(1), rec_head, rec_len};
                     end
                  end
                  default: begin
                     res_status = ST_OK;
                  end
               endcase
            end
         end

         S_WAKE: begin
            if (out_free) begin
               commit       = 1'b1;
               res_woke     = 1'b1;
               res_woke_pid = PID_PORT_W'(wait_rdata);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and captured request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= req_kind_type'(req_tuser);
         id_ff   <= in_sem_id;
         init_ff <= in_init;
         pid_ff  <= PID_BITS'(in_pid);
      end
   end

   // Result register: load on commit, drop the valid once the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff   <= res_status;
         slot_ff     <= res_slot;
         granted_ff  <= res_granted;
         woke_ff     <= res_woke;
         woke_pid_ff <= res_woke_pid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, woke_pid_ff, woke_ff, granted_ff, slot_ff, status_ff};

endmodule

@@ rtl/csem_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module csem_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/csem_slot_map.sv @@
`timescale 1ns / 1ps
// Slot occupancy flags with a registered lowest-free-slot search.
// Depends on csem_pkg.
module csem_slot_map #(
   parameter int NUM_SEMS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  csem_pkg::map_op_type        op,
   input  logic [$clog2(NUM_SEMS)-1:0] op_idx,
   input  logic [$clog2(NUM_SEMS)-1:0] look_idx,
   output logic                        look_open,
   output logic                        any_free,
   output logic [$clog2(NUM_SEMS)-1:0] free_idx
);
   import csem_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SEMS);

   logic [NUM_SEMS-1:0] open_ff;
   logic                any_free_ff;
   logic [SLOT_W-1:0]   free_idx_ff;
   logic                any_free_in;
   logic [SLOT_W-1:0]   free_idx_in;

   // lowest clear flag wins
   always_comb begin
      any_free_in = 1'b0;
      free_idx_in = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!open_ff[i]) begin
            any_free_in = 1'b1;
            free_idx_in = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= '0;
         any_free_ff <= 1'b0;
         free_idx_ff <= '0;
      end else begin
         if (op.set) begin
            open_ff[op_idx] <= 1'b1;
         end else if (op.clr) begin
            open_ff[op_idx] <= 1'b0;
         end
         any_free_ff <= any_free_in;
         free_idx_ff <= free_idx_in;
      end
   end

   assign look_open = open_ff[look_idx];
   assign any_free  = any_free_ff;
   assign free_idx  = free_idx_ff;

endmodule
